// File: sv/vhmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vhmn_pkg
// Shared types, constants and helper functions of the voxel hex mesh
// numbering block.
// ----------------------------------------------------------------------------
package vhmn_pkg;

    // Default largest volume along each axis.
    localparam int VHMN_MAX_CELLS_X = 32;
    localparam int VHMN_MAX_CELLS_Y = 32;
    localparam int VHMN_MAX_CELLS_Z = 32;

    // Fixed field widths.
    localparam int OCC_W   = 8;
    localparam int SIZE_W  = 6;
    localparam int CNUM_W  = 15;
    localparam int COUNT_W = 16;
    localparam int SLOT_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Size register reset value.
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE_X = 2'd0,
        CFG_SIZE_Y = 2'd1,
        CFG_SIZE_Z = 2'd2
    } vhmn_cfg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_PREP_MUL,
        ST_PREP_TOT,
        ST_DIV_X,
        ST_DIV_Y,
        ST_BASE_ROW,
        ST_BASE,
        ST_IDLE,
        ST_CORNERS
    } vhmn_state_t;

    // A size of zero acts as one, a size above the axis maximum acts as it.
    function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v, int maxv);
        logic [SIZE_W-1:0] s;
        s = v;
        if (s == '0) begin
            s = 6'd1;
        end
        if (int'(s) > maxv) begin
            s = SIZE_W'(maxv);
        end
        return s;
    endfunction

    // Corner offset (x fastest) to hex slot: the bottom and top rings run
    // (0,0) (1,0) (1,1) (0,1).
    function automatic logic [SLOT_W-1:0] slot_of_offset(logic [2:0] o);
        return {o[2], o[1], o[1] ^ o[0]};
    endfunction

endpackage
`default_nettype wire

// File: sv/voxel_hex_mesh_numbering.sv
// The first corner word of a solid voxel passes the vertex map read register and the
// output register before it is offered; its eight corners are read and updated in turn,
// and the next voxel waits for the last; empty voxels or ones past the volume skip this.
// Reset: a clearing pass writes every one of the (MAX_CELLS_X+1)*(MAX_CELLS_Y+1)*
// (MAX_CELLS_Z+1) vertex map entries (35937 by default), then a position decode
// runs; the same decode follows each configuration write.
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_hex_mesh_numbering
// Numbers the solid voxels of a volume streamed in x-fastest order and the
// lattice corners of each, keeping vertex numbers in an on-chip vertex map.
// ----------------------------------------------------------------------------
module voxel_hex_mesh_numbering
    import vhmn_pkg::*;
#(
    parameter int MAX_CELLS_X = VHMN_MAX_CELLS_X,
    parameter int MAX_CELLS_Y = VHMN_MAX_CELLS_Y,
    parameter int MAX_CELLS_Z = VHMN_MAX_CELLS_Z
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SIZE_W-1:0]     cfg_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [OCC_W-1:0]      s_occupancy,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [CNUM_W-1:0]          m_cell_number,
    output logic [SLOT_W-1:0]          m_hex_slot,
    output logic [COUNT_W-1:0]         m_vertex_number,
    output logic                       m_is_new,
    output logic [SIZE_W-1:0]          m_lattice_x,
    output logic [SIZE_W-1:0]          m_lattice_y,
    output logic [SIZE_W-1:0]          m_lattice_z,
    output logic                       m_last_corner
);

    // Lattice geometry of the largest volume.
    localparam int LX        = MAX_CELLS_X + 1;
    localparam int LY        = MAX_CELLS_Y + 1;
    localparam int LZ        = MAX_CELLS_Z + 1;
    localparam int MAP_DEPTH = LX * LY * LZ;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int ENTRY_W   = COUNT_W + 1;

    // Sizes can never exceed what the size register holds.
    localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
    localparam int CMX = (MAX_CELLS_X < SIZE_MAX) ? MAX_CELLS_X : SIZE_MAX;
    localparam int CMY = (MAX_CELLS_Y < SIZE_MAX) ? MAX_CELLS_Y : SIZE_MAX;
    localparam int CMZ = (MAX_CELLS_Z < SIZE_MAX) ? MAX_CELLS_Z : SIZE_MAX;
    localparam int POS_W = $clog2(CMX * CMY * CMZ + 1);
    localparam int SXY_W = $clog2(CMX * CMY + 1);
    localparam int CNT_W = $clog2(POS_W + 1);
    localparam int PROD_W = SXY_W + SIZE_W;

    // Address distance of the corners one step up in y and in z.
    localparam int OFF_Y = LX;
    localparam int OFF_Z = LX * LY;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    vhmn_state_t           state_reg, state_next;
    logic                  pending_reg, pending_next;

    logic [SIZE_W-1:0]     sx_reg, sy_reg, sz_reg;
    logic [SXY_W-1:0]      sxy_reg;
    logic [POS_W-1:0]      total_reg;
    logic [AW-1:0]         ystep_reg, zrow_reg, zstep_reg;

    logic [POS_W-1:0]      pos_reg;
    logic [SIZE_W-1:0]     cx_reg, cy_reg, cz_reg;
    logic [AW-1:0]         row_reg, base_reg;

    logic [POS_W-1:0]      div_quo_reg;
    logic [SIZE_W-1:0]     div_rem_reg;
    logic [CNT_W-1:0]      div_cnt_reg;
    logic [SIZE_W-1:0]     div_divisor;
    logic [SIZE_W:0]       div_shift;
    logic                  div_ge;
    logic [SIZE_W-1:0]     div_rem_step;
    logic [POS_W-1:0]      div_quo_step;
    logic                  div_last;

    logic [AW-1:0]         clr_addr_reg;
    logic                  clear_last;

    logic [COUNT_W-1:0]    cell_count_reg;
    logic [COUNT_W-1:0]    vcount_reg;

    logic [SIZE_W-1:0]     cur_x_reg, cur_y_reg, cur_z_reg;
    logic [AW-1:0]         cur_base_reg;
    logic [CNUM_W-1:0]     cur_num_reg;

    logic [2:0]            r_idx_reg;
    logic                  r_pend_reg;
    logic                  d_valid_reg;
    logic [2:0]            d_idx_reg;
    logic [AW-1:0]         d_addr_reg;

    logic [ENTRY_W-1:0]    vmap_mem [MAP_DEPTH];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic [AW-1:0]         corner_off;

    logic                  m_valid_reg;
    logic [CNUM_W-1:0]     m_cell_number_reg;
    logic [SLOT_W-1:0]     m_hex_slot_reg;
    logic [COUNT_W-1:0]    m_vertex_number_reg;
    logic                  m_is_new_reg;
    logic [SIZE_W-1:0]     m_lattice_x_reg, m_lattice_y_reg, m_lattice_z_reg;
    logic                  m_last_corner_reg;

    logic                  clearing;
    logic                  idle_ready;
    logic                  cfg_fire;
    logic                  s_fire;
    logic                  in_range;
    logic                  solid_start;
    logic                  restart;
    logic                  d_fire;
    logic                  d_last;
    logic                  r_issue;
    logic                  entry_valid;
    logic                  x_end, y_end;

    // ------------------------------------------------------------------
    // Handshake qualifiers
    // ------------------------------------------------------------------
    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;
    assign s_ready     = idle_ready;
    assign s_fire      = s_valid && s_ready;
    assign in_range    = pos_reg < total_reg;
    assign solid_start = s_fire && in_range && (s_occupancy != '0);
    assign restart     = pending_reg || cfg_fire;
    assign clear_last  = clr_addr_reg == AW'(MAP_DEPTH - 1);

    // The corner stage retires a word whenever the output register frees up.
    assign d_fire  = d_valid_reg && (!m_valid_reg || m_ready);
    assign d_last  = d_idx_reg == 3'd7;
    assign r_issue = (state_reg == ST_CORNERS) && r_pend_reg && (!d_valid_reg || d_fire);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clear_last) state_next = ST_PREP_MUL;
            end
            ST_PREP_MUL: begin
                state_next = cfg_fire ? ST_PREP_MUL : ST_PREP_TOT;
            end
            ST_PREP_TOT: begin
                state_next = restart ? ST_PREP_MUL : ST_DIV_X;
            end
            ST_DIV_X: begin
                if (restart) state_next = ST_PREP_MUL;
                else if (div_last) state_next = ST_DIV_Y;
            end
            ST_DIV_Y: begin
                if (restart) state_next = ST_PREP_MUL;
                else if (div_last) state_next = ST_BASE_ROW;
            end
            ST_BASE_ROW: begin
                state_next = restart ? ST_PREP_MUL : ST_BASE;
            end
            ST_BASE: begin
                state_next = restart ? ST_PREP_MUL : ST_IDLE;
            end
            ST_IDLE: begin
                if (solid_start) state_next = ST_CORNERS;
                else if (restart) state_next = ST_PREP_MUL;
            end
            ST_CORNERS: begin
                if (d_fire && d_last) state_next = restart ? ST_PREP_MUL : ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        clearing   = 1'b0;
        idle_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: clearing   = 1'b1;
            ST_IDLE:  idle_ready = !pending_reg;
            default: begin
                clearing   = 1'b0;
                idle_ready = 1'b0;
            end
        endcase
    end

    // A size write forces a new position decode once the current work ends.
    assign pending_next = cfg_fire || (pending_reg && (state_reg != ST_PREP_MUL));

    // ------------------------------------------------------------------
    // Shared restoring divider, one quotient bit a cycle
    // ------------------------------------------------------------------
    assign div_divisor  = (state_reg == ST_DIV_Y) ? sy_reg : sx_reg;
    assign div_shift    = {div_rem_reg, div_quo_reg[POS_W-1]};
    assign div_ge       = div_shift >= {1'b0, div_divisor};
    assign div_rem_step = div_ge ? SIZE_W'(div_shift - {1'b0, div_divisor})
                                 : SIZE_W'(div_shift);
    assign div_quo_step = POS_W'({div_quo_reg, div_ge});
    assign div_last     = div_cnt_reg == CNT_W'(POS_W - 1);

    // ------------------------------------------------------------------
    // Vertex map ports
    // ------------------------------------------------------------------
    assign corner_off = AW'(r_idx_reg[0])
                      + (r_idx_reg[1] ? AW'(OFF_Y) : '0)
                      + (r_idx_reg[2] ? AW'(OFF_Z) : '0);
    assign rd_en       = solid_start || r_issue;
    assign rd_addr     = solid_start ? base_reg : cur_base_reg + corner_off;
    assign entry_valid = rd_data_reg[ENTRY_W-1];
    assign wr_en       = clearing || (d_fire && !entry_valid);
    assign wr_addr     = clearing ? clr_addr_reg : d_addr_reg;
    assign wr_data     = clearing ? '0 : {1'b1, vcount_reg};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            vmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= vmap_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            pending_reg  <= 1'b0;
            clr_addr_reg <= '0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            if (clearing) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
        end
    end

    // Size registers, clamped as they are written.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx_reg <= clamp_size(SIZE_RESET, MAX_CELLS_X);
            sy_reg <= clamp_size(SIZE_RESET, MAX_CELLS_Y);
            sz_reg <= clamp_size(SIZE_RESET, MAX_CELLS_Z);
        end else if (cfg_fire) begin
            unique case (cfg_index)
                CFG_SIZE_X: sx_reg <= clamp_size(cfg_data, MAX_CELLS_X);
                CFG_SIZE_Y: sy_reg <= clamp_size(cfg_data, MAX_CELLS_Y);
                CFG_SIZE_Z: sz_reg <= clamp_size(cfg_data, MAX_CELLS_Z);
                default: begin
                    sx_reg <= sx_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Volume totals, step sizes and position decode
    // ------------------------------------------------------------------
    assign x_end = cx_reg == (sx_reg - 6'd1);
    assign y_end = cy_reg == (sy_reg - 6'd1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            base_reg  <= '0;
            total_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_PREP_MUL: begin
                    sxy_reg   <= SXY_W'({6'd0, sx_reg} * {6'd0, sy_reg});
                    ystep_reg <= AW'(LX + 1 - int'(sx_reg));
                    zrow_reg  <= AW'(LX * (LY - int'(sy_reg)));
                end
                ST_PREP_TOT: begin
                    total_reg   <= POS_W'(PROD_W'(sxy_reg) * PROD_W'(sz_reg));
                    zstep_reg   <= ystep_reg + zrow_reg;
                    div_quo_reg <= pos_reg;
                    div_rem_reg <= '0;
                    div_cnt_reg <= '0;
                end
                ST_DIV_X: begin
                    if (div_last) begin
                        cx_reg      <= div_rem_step;
                        div_quo_reg <= div_quo_step;
                        div_rem_reg <= '0;
                        div_cnt_reg <= '0;
                    end else begin
                        div_quo_reg <= div_quo_step;
                        div_rem_reg <= div_rem_step;
                        div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    end
                end
                ST_DIV_Y: begin
                    if (div_last) begin
                        cy_reg <= div_rem_step;
                        cz_reg <= SIZE_W'(div_quo_step);
                    end else begin
                        div_quo_reg <= div_quo_step;
                        div_rem_reg <= div_rem_step;
                        div_cnt_reg <= div_cnt_reg + CNT_W'(1);
                    end
                end
                ST_BASE_ROW: begin
                    row_reg <= AW'(int'(cy_reg) + LY * int'(cz_reg));
                end
                ST_BASE: begin
                    base_reg <= AW'(int'(cx_reg) + LX * int'(row_reg));
                end
                ST_IDLE: begin
                    // Step the position and the corner-0 address one voxel on.
                    if (s_fire && in_range) begin
                        pos_reg <= pos_reg + POS_W'(1);
                        if (!x_end) begin
                            cx_reg   <= cx_reg + 6'd1;
                            base_reg <= base_reg + AW'(1);
                        end else if (!y_end) begin
                            cx_reg   <= '0;
                            cy_reg   <= cy_reg + 6'd1;
                            base_reg <= base_reg + ystep_reg;
                        end else begin
                            cx_reg   <= '0;
                            cy_reg   <= '0;
                            cz_reg   <= cz_reg + 6'd1;
                            base_reg <= base_reg + zstep_reg;
                        end
                    end
                end
                default: begin
                    pos_reg <= pos_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Corner read and update pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_count_reg <= '0;
            vcount_reg     <= '0;
            r_pend_reg     <= 1'b0;
            d_valid_reg    <= 1'b0;
        end else begin
            // Latch the voxel and issue the read of its first corner.
            if (solid_start) begin
                cur_x_reg      <= cx_reg;
                cur_y_reg      <= cy_reg;
                cur_z_reg      <= cz_reg;
                cur_base_reg   <= base_reg;
                cur_num_reg    <= cell_count_reg[CNUM_W-1:0];
                cell_count_reg <= cell_count_reg + COUNT_W'(1);
                d_valid_reg    <= 1'b1;
                d_idx_reg      <= 3'd0;
                d_addr_reg     <= base_reg;
                r_idx_reg      <= 3'd1;
                r_pend_reg     <= 1'b1;
            end else if (r_issue) begin
                d_valid_reg <= 1'b1;
                d_idx_reg   <= r_idx_reg;
                d_addr_reg  <= rd_addr;
                r_idx_reg   <= r_idx_reg + 3'd1;
                r_pend_reg  <= r_idx_reg != 3'd7;
            end else if (d_fire) begin
                d_valid_reg <= 1'b0;
            end

            // An unnumbered corner takes the next vertex number.
            if (d_fire && !entry_valid) begin
                vcount_reg <= vcount_reg + COUNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (d_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (d_fire) begin
            m_cell_number_reg   <= cur_num_reg;
            m_hex_slot_reg      <= slot_of_offset(d_idx_reg);
            m_vertex_number_reg <= entry_valid ? rd_data_reg[COUNT_W-1:0] : vcount_reg;
            m_is_new_reg        <= !entry_valid;
            m_lattice_x_reg     <= cur_x_reg + SIZE_W'(d_idx_reg[0]);
            m_lattice_y_reg     <= cur_y_reg + SIZE_W'(d_idx_reg[1]);
            m_lattice_z_reg     <= cur_z_reg + SIZE_W'(d_idx_reg[2]);
            m_last_corner_reg   <= d_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cell_number   = m_cell_number_reg;
    assign m_hex_slot      = m_hex_slot_reg;
    assign m_vertex_number = m_vertex_number_reg;
    assign m_is_new        = m_is_new_reg;
    assign m_lattice_x     = m_lattice_x_reg;
    assign m_lattice_y     = m_lattice_y_reg;
    assign m_lattice_z     = m_lattice_z_reg;
    assign m_last_corner   = m_last_corner_reg;

endmodule
`default_nettype wire
